// ===== hw/rtl/dtp_pkg.sv =====
// Shared types and constants of the depth-to-point unprojector.
// Holds the configuration bundle, the queue payload and the fixed formats.
// No dependencies.
package dtp_pkg;

    localparam int DEPTH_W = 26;
    localparam int POS_W   = 12;
    localparam int SIZE_W  = 13;
    localparam int CFG_W   = 32;
    localparam int COORD_W = 32;
    localparam int INDEX_W = 3;

    // Register indexes of the configuration port.
    localparam logic [INDEX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [INDEX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [INDEX_W-1:0] REG_NEAR_PLANE   = 3'd2;
    localparam logic [INDEX_W-1:0] REG_FAR_PLANE    = 3'd3;
    localparam logic [INDEX_W-1:0] REG_RANGE_LIMIT  = 3'd4;

    localparam logic [SIZE_W-1:0] RST_IMAGE_WIDTH  = 13'd640;
    localparam logic [SIZE_W-1:0] RST_IMAGE_HEIGHT = 13'd480;
    localparam logic [CFG_W-1:0]  RST_NEAR_PLANE   = 32'd2602;
    localparam logic [CFG_W-1:0]  RST_FAR_PLANE    = 32'd65536000;
    localparam logic [CFG_W-1:0]  RST_RANGE_LIMIT  = 32'd524288;

    localparam logic [SIZE_W-1:0] MAX_WIDTH  = 13'd4096;
    localparam logic [SIZE_W-1:0] MAX_HEIGHT = 13'd4096;

    // Focal length is size * FOCAL_DEN / (2 * FOCAL_NUM) after the 90 degree lens.
    localparam logic [13:0] FOCAL_NUM = 14'd10000;
    localparam logic [13:0] FOCAL_DEN = 14'd10008;

    // Depth quotient: 33 bits are enough, anything larger fails the clip test.
    localparam int ZQ_W      = 33;
    localparam int NUM_SHIFT = 25;
    localparam int PLO_W     = ZQ_W - NUM_SHIFT;
    localparam int ZDEN_W    = 59;

    // Lateral quotient divisor width (size * FOCAL_DEN).
    localparam int PDEN_W = 26;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [SIZE_W-1:0] image_width;
        logic [SIZE_W-1:0] image_height;
        logic [CFG_W-1:0]  near_plane;
        logic [CFG_W-1:0]  far_plane;
        logic [CFG_W-1:0]  range_limit;
    } dtp_cfg_t;

    // One classified sample handed from the depth front to the projection back.
    typedef struct packed {
        logic             ok;
        logic [ZQ_W-1:0]  z;
        logic [POS_W-1:0] column;
        logic [POS_W-1:0] row;
        logic             last;
    } dtp_depth_t;

endpackage

// ===== hw/rtl/dtp_front.sv =====
// Depth front: accepts samples, classifies them and computes metric depth.
// A pipelined restoring divider makes one quotient bit per stage.
// Depends on dtp_pkg.
module dtp_front
    import dtp_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  dtp_cfg_t                  cfg,
    input  logic                      push,
    output logic                      full,
    input  logic signed [DEPTH_W-1:0] depth_norm,
    input  logic [POS_W-1:0]          column,
    input  logic [POS_W-1:0]          row,
    input  logic                      frame_last,
    output logic                      fo_valid,
    output dtp_depth_t                fo_data,
    input  logic                      q_full
);

    typedef struct packed {
        logic                dpos;
        logic signed [58:0]  prod;
        logic [63:0]         nf;
        logic [32:0]         sum;
        logic [POS_W-1:0]    column;
        logic [POS_W-1:0]    row;
        logic                last;
    } fa_t;

    typedef struct packed {
        logic                dpos;
        logic [59:0]         den;
        logic [63:0]         nf;
        logic [POS_W-1:0]    column;
        logic [POS_W-1:0]    row;
        logic                last;
    } fb_t;

    typedef struct packed {
        logic                ok;
        logic [ZDEN_W-1:0]   rem;
        logic [ZDEN_W-1:0]   den;
        logic [PLO_W-1:0]    plo;
        logic [ZQ_W-1:0]     q;
        logic [POS_W-1:0]    column;
        logic [POS_W-1:0]    row;
        logic                last;
    } fd_t;

    function automatic fd_t div_step(fd_t s);
        logic [ZDEN_W:0] trial;
        logic            ge;
        fd_t             r;
        r     = s;
        trial = {s.rem, s.plo[PLO_W-1]};
        ge    = (trial >= {1'b0, s.den});
        r.rem = ge ? ZDEN_W'(trial - {1'b0, s.den}) : trial[ZDEN_W-1:0];
        r.plo = {s.plo[PLO_W-2:0], 1'b0};
        r.q   = {s.q[ZQ_W-2:0], ge};
        return r;
    endfunction

    logic en;
    logic accept;

    logic signed [32:0] diff_w;
    logic signed [58:0] prod_w;
    logic [63:0]        nf_w;
    fa_t                a_next;
    fb_t                b_next;
    fd_t                d0_next;
    logic [59:0]        den_w;

    logic a_valid_reg;
    fa_t  a_reg;
    logic b_valid_reg;
    fb_t  b_reg;
    logic [ZQ_W:0] dv_reg;
    fd_t  d_reg [0:ZQ_W];
    fd_t  d_next [1:ZQ_W];

    // The whole front moves together; it halts only when its last stage
    // holds a sample that the queue cannot take.
    assign en     = !(fo_valid && q_full);
    assign full   = !en;
    assign accept = push && en;

    assign diff_w = $signed({1'b0, cfg.far_plane}) - $signed({1'b0, cfg.near_plane});
    assign prod_w = depth_norm * diff_w;
    assign nf_w   = {32'b0, cfg.near_plane} * {32'b0, cfg.far_plane};

    always_comb
    begin
        a_next.dpos   = !depth_norm[DEPTH_W-1] && (depth_norm != '0);
        a_next.prod   = prod_w;
        a_next.nf     = nf_w;
        a_next.sum    = {1'b0, cfg.near_plane} + {1'b0, cfg.far_plane};
        a_next.column = column;
        a_next.row    = row;
        a_next.last   = frame_last;
    end

    assign den_w = {3'b0, a_reg.sum, 24'b0} - {a_reg.prod[58], a_reg.prod};

    always_comb
    begin
        b_next.dpos   = a_reg.dpos;
        b_next.den    = den_w;
        b_next.nf     = a_reg.nf;
        b_next.column = a_reg.column;
        b_next.row    = a_reg.row;
        b_next.last   = a_reg.last;
    end

    // The quotient is kept only if the denominator is positive and the
    // result fits in 33 bits (otherwise the clip test fails anyway).
    always_comb
    begin
        d0_next.ok     = b_reg.dpos && !b_reg.den[59] && (b_reg.den != '0)
                         && ({4'b0, b_reg.nf[63:PLO_W]} < b_reg.den);
        d0_next.rem    = {3'b0, b_reg.nf[63:PLO_W]};
        d0_next.den    = b_reg.den[ZDEN_W-1:0];
        d0_next.plo    = b_reg.nf[PLO_W-1:0];
        d0_next.q      = '0;
        d0_next.column = b_reg.column;
        d0_next.row    = b_reg.row;
        d0_next.last   = b_reg.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            dv_reg      <= '0;
        end
        else if (en)
        begin
            a_valid_reg <= accept;
            b_valid_reg <= a_valid_reg;
            dv_reg      <= {dv_reg[ZQ_W-1:0], b_valid_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg    <= a_next;
            b_reg    <= b_next;
            d_reg[0] <= d0_next;
        end
    end

    for (genvar k = 1; k <= ZQ_W; k++)
    begin : g_div
        assign d_next[k] = div_step(d_reg[k-1]);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d_reg[k] <= d_next[k];
            end
        end
    end

    assign fo_valid       = dv_reg[ZQ_W];
    assign fo_data.ok     = d_reg[ZQ_W].ok;
    assign fo_data.z      = d_reg[ZQ_W].q;
    assign fo_data.column = d_reg[ZQ_W].column;
    assign fo_data.row    = d_reg[ZQ_W].row;
    assign fo_data.last   = d_reg[ZQ_W].last;

endmodule

// ===== hw/rtl/dtp_queue.sv =====
// Short register queue between the depth front and the projection back.
// First-word-fall-through: the head entry is visible while not empty.
// Depends on dtp_pkg.
module dtp_queue
    import dtp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  dtp_depth_t wr_data,
    output logic       q_full,
    input  logic       rd_en,
    output dtp_depth_t rd_data,
    output logic       q_empty
);

    dtp_depth_t        mem_reg [0:QUEUE_DEPTH-1];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              do_wr;
    logic              do_rd;

    assign q_full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== hw/rtl/dtp_back.sv =====
// Projection back: lateral offsets, range test, saturation and result register.
// Two pipelined dividers run side by side, one quotient bit per stage.
// Depends on dtp_pkg.
module dtp_back
    import dtp_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  dtp_cfg_t                  cfg,
    input  logic                      q_empty,
    input  dtp_depth_t                q_data,
    output logic                      q_pop,
    output logic                      empty,
    input  logic                      pop,
    output logic signed [COORD_W-1:0] point_x,
    output logic signed [COORD_W-1:0] point_y,
    output logic signed [COORD_W-1:0] point_z,
    output logic                      point_valid,
    output logic                      frame_done
);

    typedef struct packed {
        logic              ok;
        logic [31:0]       z;
        logic [12:0]       magx;
        logic [12:0]       magy;
        logic              negx;
        logic              negy;
        logic [PDEN_W-1:0] dx;
        logic [PDEN_W-1:0] dy;
        logic              last;
    } be0_t;

    typedef struct packed {
        logic              ok;
        logic [31:0]       z;
        logic [44:0]       mx;
        logic [44:0]       my;
        logic              negx;
        logic              negy;
        logic [PDEN_W-1:0] dx;
        logic [PDEN_W-1:0] dy;
        logic              last;
    } be1_t;

    typedef struct packed {
        logic              ok;
        logic [31:0]       z;
        logic [58:0]       nx;
        logic [58:0]       ny;
        logic              negx;
        logic              negy;
        logic [PDEN_W-1:0] dx;
        logic [PDEN_W-1:0] dy;
        logic              last;
    } be2_t;

    typedef struct packed {
        logic              ok;
        logic [31:0]       z;
        logic              negx;
        logic              negy;
        logic [PDEN_W-1:0] remx;
        logic [PDEN_W-1:0] remy;
        logic [PDEN_W-1:0] dx;
        logic [PDEN_W-1:0] dy;
        logic [ZQ_W-1:0]   lox;
        logic [ZQ_W-1:0]   loy;
        logic [ZQ_W-1:0]   qx;
        logic [ZQ_W-1:0]   qy;
        logic              last;
    } bd_t;

    typedef struct packed {
        logic        ok;
        logic [31:0] z;
        logic [31:0] qx;
        logic [31:0] qy;
        logic        negx;
        logic        negy;
        logic [63:0] zz;
        logic [63:0] xx;
        logic [63:0] yy;
        logic [63:0] cc;
        logic        last;
    } bs_t;

    function automatic logic [SIZE_W-1:0] eff_size(logic [SIZE_W-1:0] s,
                                                   logic [SIZE_W-1:0] m);
        if (s == '0)
        begin
            return SIZE_W'(1);
        end
        else if (s > m)
        begin
            return m;
        end
        return s;
    endfunction

    // One restoring step on a single axis.
    function automatic logic [PDEN_W:0] lat_step(logic [PDEN_W-1:0] rem,
                                                 logic [PDEN_W-1:0] den,
                                                 logic              nb);
        logic [PDEN_W:0] trial;
        logic            ge;
        trial = {rem, nb};
        ge    = (trial >= {1'b0, den});
        return {ge, ge ? PDEN_W'(trial - {1'b0, den}) : trial[PDEN_W-1:0]};
    endfunction

    function automatic bd_t div_step(bd_t s);
        logic [PDEN_W:0] rx;
        logic [PDEN_W:0] ry;
        bd_t             r;
        r      = s;
        rx     = lat_step(s.remx, s.dx, s.lox[ZQ_W-1]);
        ry     = lat_step(s.remy, s.dy, s.loy[ZQ_W-1]);
        r.remx = rx[PDEN_W-1:0];
        r.remy = ry[PDEN_W-1:0];
        r.qx   = {s.qx[ZQ_W-2:0], rx[PDEN_W]};
        r.qy   = {s.qy[ZQ_W-2:0], ry[PDEN_W]};
        r.lox  = {s.lox[ZQ_W-2:0], 1'b0};
        r.loy  = {s.loy[ZQ_W-2:0], 1'b0};
        return r;
    endfunction

    // Negated offset: an offset of magnitude q and sign neg becomes -offset.
    function automatic logic [31:0] sat_neg(logic [31:0] q, logic neg);
        if (neg)
        begin
            return (q > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : q;
        end
        return (q > 32'h8000_0000) ? 32'h8000_0000 : (~q + 32'd1);
    endfunction

    logic en;

    logic [SIZE_W-1:0]  w_w;
    logic [SIZE_W-1:0]  h_w;
    logic signed [13:0] sx_w;
    logic signed [13:0] sy_w;
    logic [13:0]        nsx_w;
    logic [13:0]        nsy_w;
    be0_t e0_next;
    be1_t e1_next;
    be2_t e2_next;
    bd_t  d0_next;
    bs_t  s_next;
    logic [65:0] range_w;
    logic        keep_w;

    logic e0_valid_reg;
    logic e1_valid_reg;
    logic e2_valid_reg;
    logic s_valid_reg;
    logic out_valid_reg;
    logic [ZQ_W:0] dv_reg;
    be0_t e0_reg;
    be1_t e1_reg;
    be2_t e2_reg;
    bd_t  d_reg [0:ZQ_W];
    bd_t  d_next [1:ZQ_W];
    bs_t  s_reg;
    logic [31:0] px_reg;
    logic [31:0] py_reg;
    logic [31:0] pz_reg;
    logic        pvalid_reg;
    logic        pdone_reg;

    // The back moves whenever its result register is free or being taken.
    assign en    = !out_valid_reg || pop;
    assign q_pop = en && !q_empty;
    assign empty = !out_valid_reg;

    assign w_w   = eff_size(cfg.image_width, MAX_WIDTH);
    assign h_w   = eff_size(cfg.image_height, MAX_HEIGHT);
    assign sx_w  = $signed({1'b0, q_data.column, 1'b0}) - $signed({1'b0, w_w});
    assign sy_w  = $signed({1'b0, q_data.row, 1'b0}) - $signed({1'b0, h_w});
    assign nsx_w = -sx_w;
    assign nsy_w = -sy_w;

    always_comb
    begin
        e0_next.ok   = q_data.ok && (q_data.z <= {1'b0, cfg.range_limit});
        e0_next.z    = q_data.z[31:0];
        e0_next.negx = sx_w[13];
        e0_next.negy = sy_w[13];
        e0_next.magx = sx_w[13] ? nsx_w[12:0] : sx_w[12:0];
        e0_next.magy = sy_w[13] ? nsy_w[12:0] : sy_w[12:0];
        e0_next.dx   = {13'b0, w_w} * {12'b0, FOCAL_DEN};
        e0_next.dy   = {13'b0, h_w} * {12'b0, FOCAL_DEN};
        e0_next.last = q_data.last;
    end

    always_comb
    begin
        e1_next.ok   = e0_reg.ok;
        e1_next.z    = e0_reg.z;
        e1_next.mx   = {32'b0, e0_reg.magx} * {13'b0, e0_reg.z};
        e1_next.my   = {32'b0, e0_reg.magy} * {13'b0, e0_reg.z};
        e1_next.negx = e0_reg.negx;
        e1_next.negy = e0_reg.negy;
        e1_next.dx   = e0_reg.dx;
        e1_next.dy   = e0_reg.dy;
        e1_next.last = e0_reg.last;
    end

    always_comb
    begin
        e2_next.ok   = e1_reg.ok;
        e2_next.z    = e1_reg.z;
        e2_next.nx   = {14'b0, e1_reg.mx} * {45'b0, FOCAL_NUM};
        e2_next.ny   = {14'b0, e1_reg.my} * {45'b0, FOCAL_NUM};
        e2_next.negx = e1_reg.negx;
        e2_next.negy = e1_reg.negy;
        e2_next.dx   = e1_reg.dx;
        e2_next.dy   = e1_reg.dy;
        e2_next.last = e1_reg.last;
    end

    // A quotient that does not fit in 33 bits is beyond any clip distance.
    always_comb
    begin
        d0_next.ok   = e2_reg.ok && (e2_reg.nx[58:ZQ_W] < e2_reg.dx)
                       && (e2_reg.ny[58:ZQ_W] < e2_reg.dy);
        d0_next.z    = e2_reg.z;
        d0_next.negx = e2_reg.negx;
        d0_next.negy = e2_reg.negy;
        d0_next.remx = e2_reg.nx[58:ZQ_W];
        d0_next.remy = e2_reg.ny[58:ZQ_W];
        d0_next.dx   = e2_reg.dx;
        d0_next.dy   = e2_reg.dy;
        d0_next.lox  = e2_reg.nx[ZQ_W-1:0];
        d0_next.loy  = e2_reg.ny[ZQ_W-1:0];
        d0_next.qx   = '0;
        d0_next.qy   = '0;
        d0_next.last = e2_reg.last;
    end

    always_comb
    begin
        s_next.ok   = d_reg[ZQ_W].ok
                      && (d_reg[ZQ_W].qx <= {1'b0, cfg.range_limit})
                      && (d_reg[ZQ_W].qy <= {1'b0, cfg.range_limit});
        s_next.z    = d_reg[ZQ_W].z;
        s_next.qx   = d_reg[ZQ_W].qx[31:0];
        s_next.qy   = d_reg[ZQ_W].qy[31:0];
        s_next.negx = d_reg[ZQ_W].negx;
        s_next.negy = d_reg[ZQ_W].negy;
        s_next.zz   = {32'b0, d_reg[ZQ_W].z} * {32'b0, d_reg[ZQ_W].z};
        s_next.xx   = {32'b0, d_reg[ZQ_W].qx[31:0]} * {32'b0, d_reg[ZQ_W].qx[31:0]};
        s_next.yy   = {32'b0, d_reg[ZQ_W].qy[31:0]} * {32'b0, d_reg[ZQ_W].qy[31:0]};
        s_next.cc   = {32'b0, cfg.range_limit} * {32'b0, cfg.range_limit};
        s_next.last = d_reg[ZQ_W].last;
    end

    // The range sum is kept exact; a sum past 64 bits can never pass.
    assign range_w = {2'b0, s_reg.zz} + {2'b0, s_reg.xx} + {2'b0, s_reg.yy};
    assign keep_w  = s_reg.ok && (range_w <= {2'b0, s_reg.cc});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e0_valid_reg  <= 1'b0;
            e1_valid_reg  <= 1'b0;
            e2_valid_reg  <= 1'b0;
            dv_reg        <= '0;
            s_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            e0_valid_reg  <= !q_empty;
            e1_valid_reg  <= e0_valid_reg;
            e2_valid_reg  <= e1_valid_reg;
            dv_reg        <= {dv_reg[ZQ_W-1:0], e2_valid_reg};
            s_valid_reg   <= dv_reg[ZQ_W];
            out_valid_reg <= s_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e0_reg     <= e0_next;
            e1_reg     <= e1_next;
            e2_reg     <= e2_next;
            d_reg[0]   <= d0_next;
            s_reg      <= s_next;
            px_reg     <= keep_w ? ((s_reg.z > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : s_reg.z)
                                 : 32'd0;
            py_reg     <= keep_w ? sat_neg(s_reg.qx, s_reg.negx) : 32'd0;
            pz_reg     <= keep_w ? sat_neg(s_reg.qy, s_reg.negy) : 32'd0;
            pvalid_reg <= keep_w;
            pdone_reg  <= s_reg.last;
        end
    end

    for (genvar k = 1; k <= ZQ_W; k++)
    begin : g_div
        assign d_next[k] = div_step(d_reg[k-1]);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d_reg[k] <= d_next[k];
            end
        end
    end

    assign point_x     = px_reg;
    assign point_y     = py_reg;
    assign point_z     = pz_reg;
    assign point_valid = pvalid_reg;
    assign frame_done  = pdone_reg;

endmodule

// ===== hw/rtl/depth_to_point_unprojector.sv =====
// Top level of the depth-to-point unprojector: configuration registers,
// depth front, decoupling queue and projection back. Depends on dtp_pkg,
// dtp_front, dtp_queue and dtp_back.
//
// Usage. Depth samples enter as requests on a queue-style port: a request
// is taken at a clock edge where push is high and full is low. Each request
// carries depth_norm, column, row and frame_last and yields exactly one
// result request, in order, on the output port: the result is shown while
// empty is low and is taken at an edge where pop is high and empty is low.
// Throughput is one request per cycle while full stays low. Between the
// accepting edge and a result showing lie the depth front's 36 register
// stages, the first loaded at the accepting edge (33 of them are the one
// bit per stage depth divider), a queue entry register and the back's 39
// stages (33 of them the lateral dividers). Configuration is written
// through cfg_write, cfg_index and cfg_data, one register per cycle, while
// no request is in flight; unknown indexes are ignored. Reset restores the
// register defaults and empties the pipelines. When the receiver stops
// popping, the back holds its contents, the queue fills with the front's
// output, and only then does full rise; popping again moves the back and
// frees a queue entry at that edge, and full falls right after it.
module depth_to_point_unprojector
    import dtp_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [INDEX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]          cfg_data,
    input  logic                      push,
    output logic                      full,
    input  logic signed [DEPTH_W-1:0] depth_norm,
    input  logic [POS_W-1:0]          column,
    input  logic [POS_W-1:0]          row,
    input  logic                      frame_last,
    output logic                      empty,
    input  logic                      pop,
    output logic signed [COORD_W-1:0] point_x,
    output logic signed [COORD_W-1:0] point_y,
    output logic signed [COORD_W-1:0] point_z,
    output logic                      point_valid,
    output logic                      frame_done
);

    dtp_cfg_t   cfg_reg;
    logic       fo_valid;
    dtp_depth_t fo_data;
    logic       q_full;
    logic       q_empty;
    logic       q_pop;
    dtp_depth_t q_data;

    // Register writes keep only the bits each register holds.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width  <= RST_IMAGE_WIDTH;
            cfg_reg.image_height <= RST_IMAGE_HEIGHT;
            cfg_reg.near_plane   <= RST_NEAR_PLANE;
            cfg_reg.far_plane    <= RST_FAR_PLANE;
            cfg_reg.range_limit  <= RST_RANGE_LIMIT;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  cfg_reg.image_width  <= cfg_data[SIZE_W-1:0];
                REG_IMAGE_HEIGHT: cfg_reg.image_height <= cfg_data[SIZE_W-1:0];
                REG_NEAR_PLANE:   cfg_reg.near_plane   <= cfg_data;
                REG_FAR_PLANE:    cfg_reg.far_plane    <= cfg_data;
                REG_RANGE_LIMIT:  cfg_reg.range_limit  <= cfg_data;
                default:          ;
            endcase
        end
    end

    // The front turns the sample into metric depth and flags bad samples.
    dtp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .push       (push),
        .full       (full),
        .depth_norm (depth_norm),
        .column     (column),
        .row        (row),
        .frame_last (frame_last),
        .fo_valid   (fo_valid),
        .fo_data    (fo_data),
        .q_full     (q_full)
    );

    // The queue absorbs the front's output while the back is stalled.
    dtp_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (fo_valid),
        .wr_data (fo_data),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .q_empty (q_empty)
    );

    // The back projects, applies the range test and saturates the point.
    dtp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_empty     (q_empty),
        .q_data      (q_data),
        .q_pop       (q_pop),
        .empty       (empty),
        .pop         (pop),
        .point_x     (point_x),
        .point_y     (point_y),
        .point_z     (point_z),
        .point_valid (point_valid),
        .frame_done  (frame_done)
    );

endmodule

// ===== hw/rtl/dtp_checker.sv =====
// Port-level checks of the depth-to-point unprojector and their bind.
// Depends on dtp_pkg and the top level.
module dtp_checker
    import dtp_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      full,
    input logic                      empty,
    input logic                      pop,
    input logic signed [COORD_W-1:0] point_x,
    input logic signed [COORD_W-1:0] point_y,
    input logic signed [COORD_W-1:0] point_z,
    input logic                      point_valid,
    input logic                      frame_done
);

    // A result that is not taken stays put.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(point_x) && $stable(point_y)
                              && $stable(point_z) && $stable(point_valid)
                              && $stable(frame_done)))
        else $error("result changed while stalled");

    // A dropped point carries zero coordinates.
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !point_valid) |-> (point_x == 0 && point_y == 0 && point_z == 0))
        else $error("dropped point has nonzero coordinates");

    // A kept point lies in front of the sensor.
    a_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && point_valid) |-> !point_x[COORD_W-1])
        else $error("kept point has negative depth");

    // The input only backs up behind a result that is waiting to be taken.
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !empty)
        else $error("input stalled with no result waiting");

endmodule

bind depth_to_point_unprojector dtp_checker u_dtp_checker (.*);

// ===== test/tb_depth_to_point_unprojector.sv =====
// Self-checking testbench for the depth-to-point unprojector.
// Holds a scoreboard class with its own bit-exact predictor, plus the stimulus tasks.
// Depends on dtp_pkg and depth_to_point_unprojector.
`timescale 1ns / 100ps

module tb_depth_to_point_unprojector;
    import dtp_pkg::*;

    // Index with no register behind it; a write there must change nothing.
    localparam logic [INDEX_W-1:0] REG_SPARE = 3'd5;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 100;

    typedef struct {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic               valid;
        logic               done;
    } point_t;

    // Scoreboard: a copy of the registers, a predictor and the points still owed.
    class point_scoreboard;
        longint unsigned width_reg, height_reg, near_reg, far_reg, clip_reg;
        point_t          owed_points[$];
        int              errors;

        function new();
            width_reg  = 64'(RST_IMAGE_WIDTH);
            height_reg = 64'(RST_IMAGE_HEIGHT);
            near_reg   = 64'(RST_NEAR_PLANE);
            far_reg    = 64'(RST_FAR_PLANE);
            clip_reg   = 64'(RST_RANGE_LIMIT);
            errors     = 0;
        endfunction

        function void set_reg(logic [INDEX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_IMAGE_WIDTH:  width_reg  = 64'(val[SIZE_W-1:0]);
                REG_IMAGE_HEIGHT: height_reg = 64'(val[SIZE_W-1:0]);
                REG_NEAR_PLANE:   near_reg   = 64'(val);
                REG_FAR_PLANE:    far_reg    = 64'(val);
                REG_RANGE_LIMIT:  clip_reg   = 64'(val);
                default: ;
            endcase
        endfunction

        function longint unsigned clamp_size(longint unsigned s, longint unsigned lim);
            if (s == 0) return 1;
            if (s > lim) return lim;
            return s;
        endfunction

        // Lateral offset (2*pos - size) * z / (size * 1.0008), truncated toward zero.
        function longint lateral(longint unsigned pos, longint unsigned size,
                                 longint unsigned z);
            longint          s;
            longint unsigned mag, q;
            s   = longint'(2 * pos) - longint'(size);
            mag = (s < 0) ? -s : s;
            q   = (mag * z * FOCAL_NUM) / (size * FOCAL_DEN);
            return (s < 0) ? -longint'(q) : longint'(q);
        endfunction

        function logic [COORD_W-1:0] sat32(longint v);
            if (v > 64'sd2147483647) return 32'h7FFFFFFF;
            if (v < -64'sd2147483648) return 32'h80000000;
            return v[31:0];
        endfunction

        function void note_request(logic signed [DEPTH_W-1:0] depth, logic [POS_W-1:0] u,
                                   logic [POS_W-1:0] v, logic last);
            longint          d, sum, diff, den, x, y;
            logic [127:0]    num, quo, range2, clip2;
            longint unsigned z, ax, ay;
            point_t          p;
            p = '{x: '0, y: '0, z: '0, valid: 1'b0, done: last};
            d = 64'(depth);
            if (d > 0) begin
                sum  = longint'((near_reg + far_reg) << 24);
                diff = longint'(far_reg) - longint'(near_reg);
                den  = sum - d * diff;
                if (den > 0) begin
                    num = {64'd0, near_reg * far_reg} << 25;
                    quo = num / {64'd0, den};
                    z   = quo[63:0];
                    // A quotient beyond 64 bits is far outside any clip distance.
                    if (quo[127:64] == 0 && z <= clip_reg) begin
                        x  = lateral(64'(u), clamp_size(width_reg, 64'(MAX_WIDTH)), z);
                        y  = lateral(64'(v), clamp_size(height_reg, 64'(MAX_HEIGHT)), z);
                        ax = (x < 0) ? -x : x;
                        ay = (y < 0) ? -y : y;
                        range2 = {64'd0, z} * {64'd0, z} + {64'd0, ax} * {64'd0, ax}
                               + {64'd0, ay} * {64'd0, ay};
                        clip2  = {64'd0, clip_reg} * {64'd0, clip_reg};
                        if (ax <= clip_reg && ay <= clip_reg && range2 <= clip2) begin
                            p.valid = 1'b1;
                            p.x     = sat32(longint'(z));
                            p.y     = sat32(-x);
                            p.z     = sat32(-y);
                        end
                    end
                end
            end
            owed_points.insert(owed_points.size(), p);
        endfunction

        function void check_result(point_t got);
            point_t want;
            if (owed_points.size() == 0) begin
                $display("%0t: point with nothing expected: x=%h y=%h z=%h v=%b d=%b",
                         $time, got.x, got.y, got.z, got.valid, got.done);
                errors++;
                return;
            end
            want = owed_points.pop_front();
            if (got.x !== want.x) begin
                $display("%0t: point_x expected %h actual %h", $time, want.x, got.x);
                errors++;
            end
            if (got.y !== want.y) begin
                $display("%0t: point_y expected %h actual %h", $time, want.y, got.y);
                errors++;
            end
            if (got.z !== want.z) begin
                $display("%0t: point_z expected %h actual %h", $time, want.z, got.z);
                errors++;
            end
            if (got.valid !== want.valid) begin
                $display("%0t: point_valid expected %b actual %b", $time, want.valid,
                         got.valid);
                errors++;
            end
            if (got.done !== want.done) begin
                $display("%0t: frame_done expected %b actual %b", $time, want.done,
                         got.done);
                errors++;
            end
        endfunction
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_write = 1'b0;
    logic [INDEX_W-1:0]        cfg_index = '0;
    logic [CFG_W-1:0]          cfg_data = '0;
    logic                      push = 1'b0;
    logic                      full;
    logic signed [DEPTH_W-1:0] depth_norm = '0;
    logic [POS_W-1:0]          column = '0;
    logic [POS_W-1:0]          row = '0;
    logic                      frame_last = 1'b0;
    logic                      empty;
    logic                      pop = 1'b0;
    logic signed [COORD_W-1:0] point_x, point_y, point_z;
    logic                      point_valid, frame_done;

    depth_to_point_unprojector dut (.*);

    always #5 clk = ~clk;

    point_scoreboard sb = new();

    // Idle rates in percent for each side; the main sequence changes them per phase.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    // A long receiver hold-off asked for by the main sequence, counted by the receiver.
    int hold_request = 0;
    int n_sent = 0;
    int n_got = 0;

    // Receiver: pops at random, checks every accepted result against the oldest owed point.
    initial begin : receiver
        int hold;
        @(posedge clk iff rst_n);
        forever begin
            if (hold_request > 0) begin
                hold = hold_request;
                hold_request = 0;
                repeat (hold) begin
                    pop <= 1'b0;
                    @(posedge clk);
                end
            end
            pop <= ($urandom_range(99) >= recv_stall_pct);
            @(posedge clk);
            if (pop && !empty) begin
                sb.check_result('{x: point_x, y: point_y, z: point_z, valid: point_valid,
                                  done: frame_done});
                n_got++;
            end
        end
    end

    // Watchdog: gives up when neither side has moved a request for too long.
    initial begin : watchdog
        int quiet, last_count;
        quiet = 0;
        last_count = 0;
        forever begin
            @(posedge clk);
            if (n_sent + n_got != last_count) begin
                last_count = n_sent + n_got;
                quiet = 0;
            end else begin
                quiet++;
            end
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired with %0d points owed", $time,
                         sb.owed_points.size());
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Offers one request, idling first at the current rate, and waits until it is taken.
    task automatic send_sample(logic signed [DEPTH_W-1:0] d, logic [POS_W-1:0] u,
                               logic [POS_W-1:0] v, logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push       <= 1'b1;
        depth_norm <= d;
        column     <= u;
        row        <= v;
        frame_last <= last;
        @(posedge clk);
        while (full) @(posedge clk);
        sb.note_request(d, u, v, last);
        n_sent++;
    endtask

    task automatic stop_sending();
        push <= 1'b0;
        @(posedge clk);
    endtask

    // Pauses until every owed point has arrived, then lets the pipeline settle.
    task automatic drain();
        while (sb.owed_points.size() > 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [INDEX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
    endtask

    task automatic configure(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h, logic [CFG_W-1:0] n,
                             logic [CFG_W-1:0] f, logic [CFG_W-1:0] c);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_NEAR_PLANE, n);
        write_reg(REG_FAR_PLANE, f);
        write_reg(REG_RANGE_LIMIT, c);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // Random depth: mostly in the kept range, with a share near one, the special
    // values and fully random words that exercise every bit.
    function automatic logic signed [DEPTH_W-1:0] rand_depth();
        case ($urandom_range(9))
            0:       return DEPTH_W'($urandom);
            1:       return DEPTH_W'(16777216 - $urandom_range(200000));
            2: begin
                case ($urandom_range(3))
                    0:       return 26'sd0;
                    1:       return -26'sd1;
                    2:       return 26'sh1FFFFFF;
                    default: return 26'sh2000000;
                endcase
            end
            default: return DEPTH_W'($urandom_range(16777216, 1));
        endcase
    endfunction

    // Random position, mostly inside the configured size, sometimes anywhere.
    function automatic logic [POS_W-1:0] rand_pos(longint unsigned size);
        longint unsigned top;
        top = (size == 0) ? 0 : size - 1;
        if (top > 4095) top = 4095;
        if ($urandom_range(3) == 0) return POS_W'($urandom);
        return POS_W'($urandom_range(32'(top), 0));
    endfunction

    task automatic random_samples(int count);
        repeat (count)
            send_sample(rand_depth(), rand_pos(sb.width_reg), rand_pos(sb.height_reg),
                        $urandom_range(31) == 0);
        stop_sending();
    endtask

    initial begin : main
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed samples at the reset configuration: depth extremes, zero and
        // negative depth, depth near one, corner and centre pixels, a frame end.
        send_sample(26'sd0, 12'd320, 12'd240, 1'b0);
        send_sample(-26'sd1, 12'd0, 12'd0, 1'b0);
        send_sample(26'sh2000000, 12'd4095, 12'd4095, 1'b0);
        send_sample(-26'sd16777216, 12'd10, 12'd20, 1'b0);
        send_sample(26'sd1, 12'd320, 12'd240, 1'b0);
        send_sample(26'sd1, 12'd0, 12'd0, 1'b0);
        send_sample(26'sd1, 12'd639, 12'd479, 1'b0);
        send_sample(26'sd8388608, 12'd100, 12'd400, 1'b0);
        send_sample(26'sd16700000, 12'd320, 12'd240, 1'b0);
        send_sample(26'sd16770000, 12'd0, 12'd479, 1'b0);
        send_sample(26'sd16777216, 12'd320, 12'd240, 1'b0);
        send_sample(26'sh1FFFFFF, 12'd320, 12'd240, 1'b0);
        send_sample(26'sd4000000, 12'd4095, 12'd0, 1'b0);
        send_sample(26'sd4000000, 12'd0, 12'd4095, 1'b0);
        send_sample(26'sd12000000, 12'd2000, 12'd3000, 1'b1);
        stop_sending();
        drain();

        // Reset values written back, plus a write to an index with no register.
        configure(RST_IMAGE_WIDTH, RST_IMAGE_HEIGHT, RST_NEAR_PLANE, RST_FAR_PLANE,
                  RST_RANGE_LIMIT);
        write_reg(REG_SPARE, 32'hDEADBEEF);
        cfg_write <= 1'b0;
        @(posedge clk);
        random_samples(250);
        drain();

        // Thinnest and tallest image, widest depth span, unlimited range: saturation.
        send_idle_pct = 45;
        configure(32'd1, 32'd4096, 32'd1, 32'hFFFFFFFF, 32'hFFFFFFFF);
        random_samples(250);
        drain();

        // Zero width and an oversized height, moderate planes.
        send_idle_pct = 0;
        recv_stall_pct = 45;
        configure(32'd0, 32'd8191, 32'd65536, 32'd655360, 32'h7FFFFFFF);
        random_samples(250);
        drain();

        // Near beyond far, zero clip distance, largest width.
        send_idle_pct = 28;
        recv_stall_pct = 28;
        configure(32'd4096, 32'd1, 32'hFFFFFFFF, 32'd1, 32'd0);
        random_samples(150);
        drain();

        // Back to the camera defaults while the receiver holds off long enough
        // for the pipeline and its queue to fill and stall the input.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        configure(RST_IMAGE_WIDTH, RST_IMAGE_HEIGHT, RST_NEAR_PLANE, RST_FAR_PLANE,
                  32'd33554432);
        hold_request = 300;
        random_samples(200);
        drain();

        // Random configurations with mixed idling.
        repeat (3) begin
            send_idle_pct = $urandom_range(45);
            recv_stall_pct = $urandom_range(45);
            configure($urandom_range(8191), $urandom_range(8191), $urandom_range(32'h00100000, 1),
                      $urandom_range(32'h10000000, 32'h00100000), $urandom);
            random_samples(100);
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.owed_points.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
